@@ rtl/acs_pkg.sv @@
// acs_pkg: shared types and constants for the access chunk splitter.
// Depends on nothing; imported by access_chunk_splitter.

package acs_pkg;

	localparam int unsigned LINE_BYTES_DEF       = 64;
	localparam int unsigned MAX_ACCESS_BYTES_DEF = 64;

	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned SEQ_W   = 64;
	localparam int unsigned THR_W   = 8;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned CHUNK_W = 4;

	typedef struct packed {
		logic               op;
		logic [THR_W-1:0]   thread_id;
		logic [ADDR_W-1:0]  byte_address;
		logic [COUNT_W-1:0] byte_count;
	} req_item_t;

	typedef struct packed {
		logic [THR_W-1:0]  piece_thread;
		logic              piece_kind;
		logic [ADDR_W-1:0] piece_address;
		logic [SEQ_W-1:0]  sequence_number;
		logic              is_last;
	} piece_item_t;

endpackage

@@ rtl/access_chunk_splitter.sv @@
// access_chunk_splitter: top level, splits one memory access into machine accesses.
// Depends on acs_pkg for the request and piece structs and width constants.

// One request is taken per transfer on the req channel. The access is cut once
// at the first LINE_BYTES boundary it crosses, then each segment goes out as
// 8/4/2/1-byte pieces, largest first, one piece per cycle on the piece channel
// while it is not stalled, each tagged with a running 64-bit sequence number
// (first is 1) and a last marker on the final piece. An access is first loaded
// from the request, then its pieces are produced one after another; a size of 0
// is loaded and makes no piece. The request channel stalls for the whole time
// pieces are being produced, since a single address/length stepper walks the
// segments. Sizes above MAX_ACCESS_BYTES are saturated.

module access_chunk_splitter
	import acs_pkg::*;
#(
	parameter int unsigned LINE_BYTES       = LINE_BYTES_DEF,
	parameter int unsigned MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_item_t   req,
	input  logic        req_valid,
	output logic        req_stall,
	output piece_item_t piece,
	output logic        piece_valid,
	input  logic        piece_stall
);

	localparam int unsigned LINE_LB = $clog2(LINE_BYTES);
	localparam int unsigned ROOM_W  = LINE_LB + 1;
	localparam int unsigned CMP_W   = (ROOM_W > COUNT_W) ? ROOM_W : COUNT_W;
	localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(MAX_ACCESS_BYTES);
	localparam logic [ROOM_W-1:0]  LINE_SZ   = ROOM_W'(LINE_BYTES);

	// sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic               state_q;
	logic [SEQ_W-1:0]   seq_q;       // next sequence number
	logic [ADDR_W-1:0]  addr_q;      // address of the current piece
	logic [COUNT_W-1:0] seg_len_q;   // bytes left in the current segment
	logic [COUNT_W-1:0] seg2_len_q;  // bytes of the segment after the line cut
	logic [THR_W-1:0]   thread_q;
	logic               kind_q;

	logic               req_xfer;
	logic               piece_xfer;
	logic [COUNT_W-1:0] size_sat;
	logic [ROOM_W-1:0]  room;
	logic               crosses;
	logic [CHUNK_W-1:0] chunk;
	logic               seg_done;

	assign req_xfer   = req_valid && !req_stall;
	assign piece_xfer = piece_valid && !piece_stall;

	// saturate the size, then find the bytes left up to the line end;
	// the compare runs at the wider of the two widths
	always_comb begin
		size_sat = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;
		room     = LINE_SZ - {1'b0, req.byte_address[LINE_LB-1:0]};
		crosses  = CMP_W'(room) < CMP_W'(size_sat);
	end

	// greedy piece size from what remains of the segment
	always_comb begin
		if (seg_len_q[COUNT_W-1:3] != '0) begin
			chunk = CHUNK_W'(8);
		end else if (seg_len_q[2]) begin
			chunk = CHUNK_W'(4);
		end else if (seg_len_q[1]) begin
			chunk = CHUNK_W'(2);
		end else begin
			chunk = CHUNK_W'(1);
		end
	end

	assign seg_done = seg_len_q == COUNT_W'(chunk);

	assign req_stall   = state_q != ST_IDLE;
	assign piece_valid = state_q == ST_EMIT;

	always_comb begin
		piece.piece_thread    = thread_q;
		piece.piece_kind      = kind_q;
		piece.piece_address   = addr_q;
		piece.sequence_number = seq_q;
		piece.is_last         = seg_done && (seg2_len_q == '0);
	end

	// control: state and the running sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= SEQ_W'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer && size_sat != '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (piece_xfer) begin
						seq_q <= seq_q + SEQ_W'(1);
						if (piece.is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: one address adder and one length subtractor step per piece
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			addr_q   <= req.byte_address;
			thread_q <= req.thread_id;
			kind_q   <= req.op;
			if (crosses) begin
				seg_len_q  <= COUNT_W'(room);
				seg2_len_q <= size_sat - COUNT_W'(room);
			end else begin
				seg_len_q  <= size_sat;
				seg2_len_q <= '0;
			end
		end else if (piece_xfer) begin
			addr_q <= addr_q + ADDR_W'(chunk);
			if (seg_done) begin
				seg_len_q  <= seg2_len_q;
				seg2_len_q <= '0;
			end else begin
				seg_len_q <= seg_len_q - COUNT_W'(chunk);
			end
		end
	end

	// a piece on offer always has bytes behind it
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid |-> (seg_len_q != '0))
		else $error("piece offered with empty segment");

	// a transfer that is not last leaves another piece on offer
	a_more_pieces: assert property (@(posedge clk) disable iff (!arst_n)
		(piece_xfer && !piece.is_last) |=> piece_valid)
		else $error("pieces stopped before last marker");

	// pieces of one access carry consecutive sequence numbers
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(piece_xfer && !piece.is_last) |=>
			(piece.sequence_number == $past(piece.sequence_number) + SEQ_W'(1)))
		else $error("sequence number did not step by one");

	// the address advances by the size of the piece just sent
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(piece_xfer && !piece.is_last) |=>
			(piece.piece_address == $past(piece.piece_address) + ADDR_W'($past(chunk))))
		else $error("piece address step mismatch");

endmodule
